>>> hw/rtl/bba_pkg.sv
// Shared types and constants of the bitmap block allocator.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_BLOCKS  = 1024;
    localparam int DEF_MAX_REQUEST = 16;

    // Bitmap word width (one memory row)
    localparam int WORD_W = 32;

    // Fixed field widths
    localparam int CFG_W   = 11;
    localparam int REQ_W   = 5;
    localparam int BN_W    = 10;
    localparam int STAT_W  = 2;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = 11'd1024;

    // Register index taken from paddr[2]
    localparam logic REG_BLOCK_COUNT = 1'b0;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_SHORT = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_LOAD,
        ST_FIND,
        ST_END,
        ST_FREE_RD,
        ST_FREE_WR
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/bitmap_block_allocator.sv
// First-fit block allocator over a used/free bitmap held in a word memory.
// Allocation reads, loads and searches each bitmap word in turn (ST_RD, ST_LOAD, ST_FIND),
//   then closes in ST_END; a free reads and rewrites its word (ST_FREE_RD, ST_FREE_WR), and an
//   out-of-range free goes straight to ST_FREE_WR. One item at a time; the bitmap memory port
//   (one word read or written per cycle) and the find-first-zero sequencer bound the work per item.
// Reset: asynchronous, active low. After reset a clearing pass writes zero to every
//   bitmap word while s_axis_tready stays low; APB is live.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int MAX_REQUEST = DEF_MAX_REQUEST
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    // APB configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [APB_AW-1:0]   paddr,
    input  wire logic [APB_DW-1:0]   pwdata,
    output logic      [APB_DW-1:0]   prdata,
    output logic                     pready,

    // Request stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [15:0]         s_axis_tdata,   // [4:0] request_count, [14:5] block_index
    input  wire logic [0:0]          s_axis_tuser,   // [0] operation

    // Result stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [15:0]              m_axis_tdata,   // [9:0] block_number
    output logic [2:0]               m_axis_tuser,   // [0] granted, [2:1] status
    output logic                     m_axis_tlast
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int NUM_WORDS = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IDX_W     = $clog2(WORD_W);
    localparam int CNT_BITS  = $clog2(MAX_BLOCKS + 1);
    localparam int CNT_W     = (CNT_BITS > CFG_W) ? CNT_BITS : CFG_W;
    localparam int NW        = CNT_W + 1;              // block arithmetic width
    localparam int GOT_W     = $clog2(MAX_REQUEST + 1);
    localparam int RQ_W      = (GOT_W > REQ_W) ? GOT_W : REQ_W;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] block_count_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BLOCK_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            block_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BLOCK_COUNT) ? APB_DW'(block_count_reg) : '0;

    // Effective scan limit: block_count clamped to MAX_BLOCKS
    logic [NW-1:0] bc_ext;
    logic [NW-1:0] eff_limit;

    assign bc_ext    = NW'(block_count_reg);
    assign eff_limit = (bc_ext > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : bc_ext;

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic             in_op;
    logic [REQ_W-1:0] in_req;
    logic [BN_W-1:0]  in_idx;
    logic [NW-1:0]    in_idx_ext;
    logic [RQ_W-1:0]  in_req_ext;
    logic [GOT_W-1:0] in_want;
    logic             s_xfer;

    assign in_op      = s_axis_tuser[0];
    assign in_req     = s_axis_tdata[4:0];
    assign in_idx     = s_axis_tdata[14:5];
    assign in_idx_ext = NW'(in_idx);
    assign in_req_ext = RQ_W'(in_req);
    assign in_want    = (in_req_ext > RQ_W'(MAX_REQUEST)) ? GOT_W'(MAX_REQUEST)
                                                          : GOT_W'(in_req_ext);

    // ------------------------------------------------------------------
    // State and datapath registers
    // ------------------------------------------------------------------
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [WORD_W-1:0] mask_reg, mask_next;
    logic [GOT_W-1:0]  got_reg, got_next;
    logic [GOT_W-1:0]  want_reg, want_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic              hold_valid_reg, hold_valid_next;
    logic [BN_W-1:0]   hold_num_reg, hold_num_next;
    logic [BN_W-1:0]   idx_reg, idx_next;
    logic              free_err_reg, free_err_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_granted_reg, out_granted_next;
    logic [BN_W-1:0]   out_num_reg, out_num_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    // Bitmap memory: one word read or written per cycle, registered read data
    logic [WORD_W-1:0] mem [NUM_WORDS];
    logic [WORD_W-1:0] mem_q_reg;
    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= mem_wdata;
        end
        mem_q_reg <= mem[addr_reg];
    end

    // ------------------------------------------------------------------
    // Scan helpers
    // ------------------------------------------------------------------
    logic [NW-1:0]     base;
    logic [NW-1:0]     rem;
    logic              last_word;
    logic [WORD_W-1:0] search;
    logic              found;
    logic [IDX_W-1:0]  pos;
    logic [NW-1:0]     grant_num;
    logic              out_free;
    logic              want_met;
    logic              find_grant;
    logic              find_stall;
    logic              word_done;
    logic [RQ_W-1:0]   got_ext;
    logic [RQ_W-1:0]   req_ext;

    assign base      = NW'({addr_reg, {IDX_W{1'b0}}});
    assign rem       = eff_limit - base;
    assign last_word = (base + NW'(WORD_W)) >= eff_limit;

    // Blocks at or beyond the limit look used to the search
    assign search = word_reg | mask_reg;
    assign found  = ~&search;

    // Lowest zero bit
    always_comb
    begin
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!search[i])
            begin
                pos = IDX_W'(i);
            end
        end
    end

    assign grant_num  = base + NW'(pos);
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign want_met   = (got_reg == want_reg);
    assign find_grant = !want_met && found;
    // A new grant pushes the held one out; it waits while the output slot is full
    assign find_stall = find_grant && hold_valid_reg && !out_free;
    assign word_done  = want_met || !found;
    assign got_ext    = RQ_W'(got_reg);
    assign req_ext    = RQ_W'(req_reg);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (addr_reg == ADDR_W'(NUM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    if (in_op == OP_FREE)
                    begin
                        state_next = (in_idx_ext < eff_limit) ? ST_FREE_RD : ST_FREE_WR;
                    end
                    else if ((in_want == '0) || (eff_limit == '0))
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD:      state_next = ST_LOAD;
            ST_LOAD:    state_next = ST_FIND;
            ST_FIND:
            begin
                if (word_done)
                begin
                    state_next = (want_met || last_word) ? ST_END : ST_RD;
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FREE_RD: state_next = ST_FREE_WR;
            ST_FREE_WR:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory control
    // ------------------------------------------------------------------
    always_comb
    begin
        addr_next        = addr_reg;
        word_next        = word_reg;
        mask_next        = mask_reg;
        got_next         = got_reg;
        want_next        = want_reg;
        req_next         = req_reg;
        hold_valid_next  = hold_valid_reg;
        hold_num_next    = hold_num_reg;
        idx_next         = idx_reg;
        free_err_next    = free_err_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_granted_next = out_granted_reg;
        out_num_next     = out_num_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;
        mem_we           = 1'b0;
        mem_wdata        = word_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                addr_next = (addr_reg == ADDR_W'(NUM_WORDS - 1)) ? '0 : addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (s_xfer)
                begin
                    req_next        = in_req;
                    want_next       = in_want;
                    got_next        = '0;
                    hold_valid_next = 1'b0;
                    idx_next        = in_idx;
                    free_err_next   = !(in_idx_ext < eff_limit);
                    addr_next       = (in_op == OP_FREE) ? in_idx_ext[IDX_W +: ADDR_W] : '0;
                end
            end
            ST_RD:
            begin
            end
            ST_LOAD:
            begin
                word_next = mem_q_reg;
                if (rem >= NW'(WORD_W))
                begin
                    mask_next = '0;
                end
                else
                begin
                    mask_next = {WORD_W{1'b1}} << rem[IDX_W-1:0];
                end
            end
            ST_FIND:
            begin
                if (word_done)
                begin
                    // Write back the word with its new grants
                    mem_we = 1'b1;
                    if (!want_met && !last_word)
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
                else if (!find_stall)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next   = 1'b1;
                        out_granted_next = 1'b1;
                        out_num_next     = hold_num_reg;
                        out_status_next  = STATUS_OK;
                        out_last_next    = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_num_next   = grant_num[BN_W-1:0];
                    word_next[pos]  = 1'b1;
                    got_next        = got_reg + 1'b1;
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    if (hold_valid_reg)
                    begin
                        out_granted_next = 1'b1;
                        out_num_next     = hold_num_reg;
                        out_status_next  = (got_ext < req_ext) ? STATUS_SHORT : STATUS_OK;
                    end
                    else
                    begin
                        out_granted_next = 1'b0;
                        out_num_next     = '0;
                        out_status_next  = (req_reg == '0) ? STATUS_OK : STATUS_SHORT;
                    end
                end
            end
            ST_FREE_RD:
            begin
            end
            ST_FREE_WR:
            begin
                // Rewriting while stalled is harmless: same data each cycle
                if (!free_err_reg)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_q_reg & ~(WORD_W'(1) << idx_reg[IDX_W-1:0]);
                end
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = 1'b0;
                    out_num_next     = '0;
                    out_status_next  = free_err_reg ? STATUS_RANGE : STATUS_OK;
                    out_last_next    = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            addr_reg       <= '0;
            got_reg        <= '0;
            want_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            got_reg        <= got_next;
            want_reg       <= want_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg        <= word_next;
        mask_reg        <= mask_next;
        req_reg         <= req_next;
        hold_num_reg    <= hold_num_next;
        idx_reg         <= idx_next;
        free_err_reg    <= free_err_next;
        out_granted_reg <= out_granted_next;
        out_num_reg     <= out_num_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    // ------------------------------------------------------------------
    // Result stream
    // ------------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = 16'(out_num_reg);
    assign m_axis_tuser  = {out_status_reg, out_granted_reg};
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_got_le_want: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIND) |-> (got_reg <= want_reg))
        else $error("grant count exceeds clamped request");

    a_hold_has_grant: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (got_reg != '0))
        else $error("held grant without a counted grant");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIND) |-> (base < eff_limit))
        else $error("scan word beyond block limit");

    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_granted_reg) |-> (NW'(out_num_reg) < eff_limit))
        else $error("granted block beyond block limit");

    a_no_grant_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FREE_WR && out_free) |=> (!out_granted_reg && out_last_reg))
        else $error("free result must be a single non-grant result");

endmodule

`default_nettype wire

>>> verif/bba_alloc_checker.sv
// Checker for the bitmap block allocator: bus monitor, grant prediction and result compare.
`timescale 1ns / 1ps

module bba_alloc_checker
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int MAX_REQUEST = DEF_MAX_REQUEST
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    input  wire logic              pready,

    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [15:0]       s_axis_tdata,   // [4:0] request_count, [14:5] block_index
    input  wire logic [0:0]        s_axis_tuser,   // [0] operation

    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [15:0]       m_axis_tdata,   // [9:0] block_number
    input  wire logic [2:0]        m_axis_tuser,   // [0] granted, [2:1] status
    input  wire logic              m_axis_tlast,

    output int                     fail_count,
    output int                     pending_results
);

    typedef struct packed {
        logic              granted;
        logic [BN_W-1:0]   number;
        logic [STAT_W-1:0] status;
        logic              last;
    } alloc_result_t;

    logic [MAX_BLOCKS-1:0] used_bits;
    logic [CFG_W-1:0]      block_count_q;
    alloc_result_t         expected_results[$];
    int                    fails = 0;
    int                    pend  = 0;

    assign fail_count      = fails;
    assign pending_results = pend;

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
        fails++;
    endtask

    // First-fit scan over the used map, clamped count and request; frees clear their bit
    task automatic predict_grants(input logic op, input logic [REQ_W-1:0] req,
                                  input logic [BN_W-1:0] idx);
        int            lim;
        int            want;
        int            got;
        alloc_result_t held;
        lim  = (block_count_q > MAX_BLOCKS) ? MAX_BLOCKS : int'(block_count_q);
        want = (req > MAX_REQUEST) ? MAX_REQUEST : int'(req);
        got  = 0;
        held = '0;
        if (op == OP_FREE)
        begin
            held.last = 1'b1;
            if (idx < lim)
            begin
                used_bits[idx] = 1'b0;
                held.status = STATUS_OK;
            end
            else
                held.status = STATUS_RANGE;
            expected_results.push_back(held);
            return;
        end
        for (int i = 0; i < lim && got < want; i++)
        begin
            if (!used_bits[i])
            begin
                used_bits[i] = 1'b1;
                if (got > 0)
                    expected_results.push_back(held);
                held         = '0;
                held.granted = 1'b1;
                held.number  = i[BN_W-1:0];
                held.status  = STATUS_OK;
                got++;
            end
        end
        if (got == 0)
        begin
            held        = '0;
            held.status = (req == 0) ? STATUS_OK : STATUS_SHORT;
        end
        else
            held.status = (got < req) ? STATUS_SHORT : STATUS_OK;
        held.last = 1'b1;
        expected_results.push_back(held);
    endtask

    task automatic check_result(input alloc_result_t seen);
        alloc_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result transfer with none pending", 0, 1);
            return;
        end
        want = expected_results.pop_front();
        if (seen.granted !== want.granted)
            report_mismatch("granted", want.granted, seen.granted);
        if (seen.number !== want.number)
            report_mismatch("block_number", want.number, seen.number);
        if (seen.status !== want.status)
            report_mismatch("status", want.status, seen.status);
        if (seen.last !== want.last)
            report_mismatch("last", want.last, seen.last);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_bits     = '0;
            block_count_q = BLOCK_COUNT_RST;
            expected_results.delete();
            pend          = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_BLOCK_COUNT)
                block_count_q = pwdata[CFG_W-1:0];
            if (s_axis_tvalid && s_axis_tready)
                predict_grants(s_axis_tuser[0], s_axis_tdata[REQ_W-1:0],
                               s_axis_tdata[REQ_W +: BN_W]);
            if (m_axis_tvalid && m_axis_tready)
                check_result({m_axis_tuser[0], m_axis_tdata[BN_W-1:0],
                              m_axis_tuser[2:1], m_axis_tlast});
            pend = expected_results.size();
        end
    end

endmodule

>>> verif/tb_bitmap_block_allocator.sv
// Top-level testbench of the bitmap block allocator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_bitmap_block_allocator;
    import bba_pkg::*;

    // Register 0 sits at byte address 0; paddr[2] picks the register
    localparam logic [APB_AW-1:0] BLOCK_COUNT_ADDR = {REG_BLOCK_COUNT, 2'b00};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // APB side, idle from time zero
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Request and result streams
    logic        s_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_tdata  = '0;      // [4:0] request_count, [14:5] block_index
    logic [0:0]  s_tuser  = '0;      // [0] operation
    logic        m_axis_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // [9:0] block_number
    logic [2:0]  m_axis_tuser;       // [0] granted, [2:1] status
    logic        m_axis_tlast;

    int fail_count;
    int pending_results;

    // Effective block count as the stimulus sees it (clamped to the map size)
    int cur_count = DEF_MAX_BLOCKS;
    // Set for the closing part of the run: no stalls on either side
    logic quiet = 1'b0;

    bitmap_block_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    bba_alloc_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .s_axis_tvalid   (s_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_tdata),
        .s_axis_tuser    (s_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // Hard stop. Slowest legal run: ~130 items, each with a scan of the whole map,
    // up to 16 results each with result-side stalls, plus sender gaps; 5 ms leaves
    // ample margin over that.
    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random stall bursts, none once quiet is set
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (quiet)
                m_tready <= 1'b1;
            else if (stall > 0)
                stall--;
            else if ($urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                stall = $urandom_range(1, 16) - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // One request transfer; may leave a random gap after it. Called at a rising edge.
    task automatic send_request(input logic op, input int req, input int idx);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, idx[BN_W-1:0], req[REQ_W-1:0]};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    // Hold off requests until every expected result is back and the block takes
    // new work again. Sampled on the falling edge to stay clear of the checker.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results != 0 || !s_axis_tready);
        @(posedge clk);
    endtask

    // Block count write: drain first, then setup and access phases
    task automatic set_block_count(input int value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BLOCK_COUNT_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_count = (value > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : value;
    endtask

    // Mostly allocations with modest counts, a quarter frees (mostly in range,
    // some past the count), occasional zero and oversized requests.
    task automatic send_random_item();
        int pick;
        int req;
        int idx;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            if (cur_count > 0 && $urandom_range(0, 7) != 0)
                idx = $urandom_range(0, cur_count - 1);
            else if (cur_count >= DEF_MAX_BLOCKS)
                idx = $urandom_range(0, DEF_MAX_BLOCKS - 1);
            else
                idx = $urandom_range(cur_count, DEF_MAX_BLOCKS - 1);
            send_request(OP_FREE, $urandom_range(0, 31), idx);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                req = 0;
            else if (pick < 75)
                req = $urandom_range(1, 8);
            else if (pick < 92)
                req = $urandom_range(9, DEF_MAX_REQUEST);
            else
                req = $urandom_range(DEF_MAX_REQUEST + 1, 31);
            send_request(OP_ALLOC, req, $urandom_range(0, DEF_MAX_BLOCKS - 1));
        end
    endtask

    initial
    begin
        int phase_counts[6];
        phase_counts = '{40, 1024, 13, 1, 300, 1024};
        phase_counts[3] = $urandom_range(1, DEF_MAX_BLOCKS);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed part ----
        // Small map: plain grants, a short grant, a full map, frees in and out of range
        set_block_count(8);
        send_request(OP_ALLOC, 0, 0);                       // zero request
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_ALLOC, 3, 0);
        send_request(OP_ALLOC, DEF_MAX_REQUEST, 0);         // only 4 left: short
        send_request(OP_ALLOC, 1, 0);                       // map full: empty, short
        send_request(OP_FREE, 0, 0);
        send_request(OP_FREE, 0, 7);                        // highest block in range
        send_request(OP_FREE, 0, 8);                        // just past the count
        send_request(OP_FREE, 31, DEF_MAX_BLOCKS - 1);      // far past the count
        send_request(OP_FREE, 0, 0);                        // block already free
        send_request(OP_ALLOC, 31, DEF_MAX_BLOCKS - 1);     // oversized request

        // Full map: maximum request, oversized request, top block
        set_block_count(DEF_MAX_BLOCKS);
        send_request(OP_ALLOC, DEF_MAX_REQUEST, 0);
        send_request(OP_ALLOC, DEF_MAX_REQUEST + 1, 0);
        send_request(OP_FREE, 0, DEF_MAX_BLOCKS - 1);
        send_request(OP_ALLOC, 1, 0);

        // Single block, already taken from earlier
        set_block_count(1);
        send_request(OP_ALLOC, 2, 0);
        send_request(OP_FREE, 0, 0);
        send_request(OP_ALLOC, 2, 0);

        // Count of zero scans nothing and ranges out every free
        set_block_count(0);
        send_request(OP_ALLOC, 1, 0);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_FREE, 0, 0);

        // Count above the map size is clamped
        set_block_count(2047);
        send_request(OP_ALLOC, 5, 0);
        send_request(OP_FREE, 0, DEF_MAX_BLOCKS - 1);

        // ---- Random part: six settings, about 18 items each ----
        for (int ph = 0; ph < 6; ph++)
        begin
            set_block_count(phase_counts[ph]);
            if (ph == 5)
                quiet = 1'b1;                               // closing stretch runs flat out
            for (int n = 0; n < 18; n++)
            begin
                if (ph == 2 && n == 9)
                    wait_drained();                         // let the result side catch up
                send_random_item();
            end
        end

        // Drain, then leave room for any stray result transfer
        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
